### src/vfpa_pkg.sv
// package: types, constants and state codes of the voxel forward-projection accumulator
`default_nettype none
package vfpa_pkg;

    localparam int unsigned NUM_VIEWS_DEF  = 32;
    localparam int unsigned NUM_ROWS_DEF   = 128;
    localparam int unsigned TIME_CELLS_DEF = 8;

    localparam int unsigned CFG_IW = 2;
    localparam int unsigned CFG_DW = 16;
    localparam int unsigned T_W    = 7;

    localparam logic [1:0] KIND_ACCUM = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [CFG_IW-1:0] REG_PITCH      = 2'd0;
    localparam logic [CFG_IW-1:0] REG_OVERLAP    = 2'd1;
    localparam logic [CFG_IW-1:0] REG_CELLS_USED = 2'd2;

    localparam logic [15:0] PITCH_RST      = 16'd256;
    localparam logic [3:0]  OVERLAP_RST    = 4'd1;
    localparam logic [3:0]  CELLS_USED_RST = 4'd8;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         view_index;
        logic [6:0]         row_index;
        logic [2:0]         slice_index;
        logic signed [15:0] voxel_value;
        logic [15:0]        coefficient;
        logic [2:0]         cell_index;
        logic signed [31:0] cell_value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               saturated;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_ROUND,
        ST_ACC,
        ST_WRITE,
        ST_READ,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic acc_step;
        logic wr_cell;
        logic rd_cell;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic last_cell;
        logic zero_overlap;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

### src/vfpa_ctrl.sv
// controller: sequences accumulate, write and read items
`default_nettype none
module vfpa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [1:0]        in_kind,
    output logic                   in_ready,
    input  wire vfpa_pkg::status_t status,
    output vfpa_pkg::cmd_t         cmd
);

    vfpa_pkg::state_t state_reg;
    vfpa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vfpa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vfpa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_kind)
                        vfpa_pkg::KIND_ACCUM: state_next = vfpa_pkg::ST_MUL1;
                        vfpa_pkg::KIND_WRITE: state_next = vfpa_pkg::ST_WRITE;
                        vfpa_pkg::KIND_READ:  state_next = vfpa_pkg::ST_READ;
                        default:              state_next = vfpa_pkg::ST_IDLE;
                    endcase
                end
            end
            vfpa_pkg::ST_MUL1:  state_next = vfpa_pkg::ST_MUL2;
            vfpa_pkg::ST_MUL2:  state_next = vfpa_pkg::ST_ROUND;
            vfpa_pkg::ST_ROUND:
            begin
                state_next = status.zero_overlap ? vfpa_pkg::ST_IDLE : vfpa_pkg::ST_ACC;
            end
            vfpa_pkg::ST_ACC:
            begin
                if (status.last_cell)
                begin
                    state_next = vfpa_pkg::ST_IDLE;
                end
            end
            vfpa_pkg::ST_WRITE: state_next = vfpa_pkg::ST_IDLE;
            vfpa_pkg::ST_READ:  state_next = vfpa_pkg::ST_RESP;
            vfpa_pkg::ST_RESP:
            begin
                if (status.out_free)
                begin
                    state_next = vfpa_pkg::ST_IDLE;
                end
            end
            default:            state_next = vfpa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            vfpa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            vfpa_pkg::ST_ACC:   cmd.acc_step = 1'b1;
            vfpa_pkg::ST_WRITE: cmd.wr_cell  = 1'b1;
            vfpa_pkg::ST_READ:  cmd.rd_cell  = 1'b1;
            vfpa_pkg::ST_RESP:  cmd.load_out = status.out_free;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### src/vfpa_datapath.sv
// datapath: config registers, product pipeline, sinogram memory and output register
`default_nettype none
module vfpa_datapath #(
    parameter int unsigned NUM_VIEWS  = vfpa_pkg::NUM_VIEWS_DEF,
    parameter int unsigned NUM_ROWS   = vfpa_pkg::NUM_ROWS_DEF,
    parameter int unsigned TIME_CELLS = vfpa_pkg::TIME_CELLS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire vfpa_pkg::in_word_t            in_word,
    input  wire vfpa_pkg::cmd_t                cmd,
    output vfpa_pkg::status_t                  status,
    input  wire logic                          cfg_we,
    input  wire logic [vfpa_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [vfpa_pkg::CFG_DW-1:0]   cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output vfpa_pkg::out_word_t                out_word
);

    localparam int unsigned DEPTH = NUM_VIEWS * NUM_ROWS * TIME_CELLS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned TW    = vfpa_pkg::T_W;

    logic [15:0] pitch_reg;
    logic [3:0]  overlap_reg;
    logic [3:0]  cells_used_reg;

    vfpa_pkg::in_word_t  item_reg;
    logic [AW-1:0]       base_reg;
    logic [AW-1:0]       base_next;
    logic                vr_ok_reg;
    logic                vr_ok_next;
    logic [TW-1:0]       t_reg;
    logic [3:0]          n_reg;

    logic signed [32:0]  p1_full;
    logic signed [31:0]  prod1_reg;
    logic signed [48:0]  p2_full;
    logic signed [47:0]  prod2_reg;
    logic signed [47:0]  rnd;
    logic signed [27:0]  delta_reg;

    logic [AW-1:0]       acc_addr;
    logic [AW-1:0]       cell_addr;
    logic                acc_ok;
    logic                item_ok;

    logic                wr_pend_reg;
    logic [AW-1:0]       wr_addr_reg;
    logic [31:0]         rdata_reg;
    logic signed [32:0]  sum;
    logic                sat;
    logic [31:0]         clamped;
    logic                sat_reg;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [31:0]         mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [31:0]         mem [DEPTH];

    logic                out_valid_reg;
    vfpa_pkg::out_word_t out_word_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg      <= vfpa_pkg::PITCH_RST;
            overlap_reg    <= vfpa_pkg::OVERLAP_RST;
            cells_used_reg <= vfpa_pkg::CELLS_USED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vfpa_pkg::REG_PITCH:      pitch_reg      <= cfg_data;
                vfpa_pkg::REG_OVERLAP:    overlap_reg    <= cfg_data[3:0];
                vfpa_pkg::REG_CELLS_USED: cells_used_reg <= cfg_data[3:0];
                default:                  pitch_reg      <= pitch_reg;
            endcase
        end
    end

    // row base address from the incoming word
    assign base_next  = (AW'(in_word.view_index) * AW'(NUM_ROWS) + AW'(in_word.row_index))
                        * AW'(TIME_CELLS);
    assign vr_ok_next = (32'(in_word.view_index) < NUM_VIEWS)
                        && (32'(in_word.row_index) < NUM_ROWS);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg  <= in_word;
            base_reg  <= base_next;
            vr_ok_reg <= vr_ok_next;
        end
    end

    // product pipeline: voxel * coefficient, then * pitch, then round to q16.16
    assign p1_full = 33'(item_reg.voxel_value) * $signed(33'(item_reg.coefficient));
    assign p2_full = 49'(prod1_reg) * $signed(49'(pitch_reg));
    assign rnd     = prod2_reg + 48'sd524288;

    always_ff @(posedge clk)
    begin
        prod1_reg <= p1_full[31:0];
        prod2_reg <= p2_full[47:0];
        delta_reg <= rnd[47:20];
    end

    // cell counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg <= '0;
            n_reg <= '0;
        end
        else if (cmd.load)
        begin
            t_reg <= TW'(in_word.slice_index) * TW'(overlap_reg);
            n_reg <= '0;
        end
        else if (cmd.acc_step)
        begin
            t_reg <= t_reg + TW'(1);
            n_reg <= n_reg + 4'd1;
        end
    end

    assign acc_addr  = base_reg + AW'(t_reg);
    assign cell_addr = base_reg + AW'(item_reg.cell_index);
    assign acc_ok    = vr_ok_reg && (t_reg < TW'(cells_used_reg))
                       && (32'(t_reg) < TIME_CELLS);
    assign item_ok   = vr_ok_reg && (32'(item_reg.cell_index) < TIME_CELLS);

    // read-modify-write: read, then saturating add and write in the following cycle
    assign sum     = 33'($signed(rdata_reg)) + 33'(delta_reg);
    assign sat     = sum[32] ^ sum[31];
    assign clamped = sat ? (sum[32] ? 32'h8000_0000 : 32'h7fff_ffff) : sum[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pend_reg <= 1'b0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= cmd.acc_step && acc_ok;
            sat_reg     <= sat_reg | (wr_pend_reg & sat);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_step)
        begin
            wr_addr_reg <= acc_addr;
        end
    end

    assign mem_we    = wr_pend_reg || (cmd.wr_cell && item_ok);
    assign mem_waddr = wr_pend_reg ? wr_addr_reg : cell_addr;
    assign mem_wdata = wr_pend_reg ? clamped : 32'(item_reg.cell_value);
    assign mem_re    = cmd.acc_step || cmd.rd_cell;
    assign mem_raddr = cmd.acc_step ? acc_addr : cell_addr;

    // sinogram memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_word_reg.read_value <= item_ok ? $signed(rdata_reg) : 32'sd0;
            out_word_reg.saturated  <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign status.last_cell    = (5'(n_reg) + 5'd1) == 5'(overlap_reg);
    assign status.zero_overlap = (overlap_reg == 4'd0);
    assign status.out_free     = !out_valid_reg || out_ready;

endmodule
`default_nettype wire

### src/voxel_forward_projection_accumulate_top.sv
// top level: voxel forward-projection accumulator over an error sinogram
//
// holds an error sinogram of NUM_VIEWS x NUM_ROWS x TIME_CELLS signed q16.16 words in one
// simple dual-port memory with registered read. one word at a time: an accumulate word goes
// through capture, two multiplier stages and rounding, then z_overlap cells one per cycle
// through the memory read-modify-write, whose last write lands in the following cycle; a write
// word is captured and written; a read word is read and waits for the output register to free.
// the memory has no reset, so cells must be written before they are read or accumulated into.
// configuration writes are taken at any time and should be made only while the block is idle.
`default_nettype none
module voxel_forward_projection_accumulate_top #(
    parameter int unsigned NUM_VIEWS  = vfpa_pkg::NUM_VIEWS_DEF,
    parameter int unsigned NUM_ROWS   = vfpa_pkg::NUM_ROWS_DEF,
    parameter int unsigned TIME_CELLS = vfpa_pkg::TIME_CELLS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire vfpa_pkg::in_word_t          in_word,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output vfpa_pkg::out_word_t              out_word,
    input  wire logic                        cfg_we,
    input  wire logic [vfpa_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [vfpa_pkg::CFG_DW-1:0] cfg_data
);

    vfpa_pkg::cmd_t    cmd;
    vfpa_pkg::status_t status;

    vfpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (in_word.kind),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    vfpa_datapath #(
        .NUM_VIEWS  (NUM_VIEWS),
        .NUM_ROWS   (NUM_ROWS),
        .TIME_CELLS (TIME_CELLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // output register is only loaded when it is free
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("output register loaded while still full");

    // one word at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_word.kind <= vfpa_pkg::KIND_READ) |=> !in_ready)
        else $error("new word accepted while previous word in progress");

    // memory port users never collide
    a_single_user: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_step |-> !cmd.wr_cell && !cmd.rd_cell && !cmd.load_out)
        else $error("accumulate step overlaps another memory operation");

endmodule
`default_nettype wire
